@@ rtl/tdh_pkg.sv @@
// Shared types and codes for the tap detector with hold time and cooldown.
// No dependencies; imported by every other file of the block.
package tdh_pkg;

    localparam int StateW = 3;
    localparam int TimeW  = 32;
    localparam int CfgW   = 16;
    localparam int AddrW  = 2;

    localparam logic [StateW-1:0] ST_IDLE      = 3'd0;
    localparam logic [StateW-1:0] ST_TRAINING  = 3'd1;
    localparam logic [StateW-1:0] ST_DETECTING = 3'd2;
    localparam logic [StateW-1:0] ST_TRIGGERED = 3'd3;
    localparam logic [StateW-1:0] ST_COOLDOWN  = 3'd4;

    localparam logic [1:0] FN_UPDATE = 2'd0;
    localparam logic [1:0] FN_START  = 2'd1;
    localparam logic [1:0] FN_STOP   = 2'd2;
    localparam logic [1:0] FN_RESET  = 2'd3;

    localparam logic [AddrW-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [AddrW-1:0] REG_HOLD      = 2'd1;
    localparam logic [AddrW-1:0] REG_COOLDOWN  = 2'd2;

    localparam logic [CfgW-1:0] THRESHOLD_RST = 16'd22938;
    localparam logic [CfgW-1:0] HOLD_RST      = 16'd100;
    localparam logic [CfgW-1:0] COOLDOWN_RST  = 16'd500;

    typedef struct packed {
        logic [CfgW-1:0] threshold;
        logic [CfgW-1:0] hold_ms;
        logic [CfgW-1:0] cooldown_ms;
    } cfg_t;

    typedef struct packed {
        logic [StateW-1:0] next_state;
        logic              changed;
        logic              fired;
        logic [TimeW-1:0]  next_time;
    } step_t;

endpackage

@@ rtl/tdh_cfg_regs.sv @@
// Configuration register file: threshold, hold time and cooldown time.
// Depends on tdh_pkg.
module tdh_cfg_regs
    import tdh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [AddrW-1:0] cfg_addr,
    input  logic [CfgW-1:0]  cfg_wdata,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_THRESHOLD: cfg_next.threshold   = cfg_wdata;
                REG_HOLD:      cfg_next.hold_ms     = cfg_wdata;
                REG_COOLDOWN:  cfg_next.cooldown_ms = cfg_wdata;
                default:       cfg_next = cfg_reg; // drop writes to unused index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold   <= THRESHOLD_RST;
            cfg_reg.hold_ms     <= HOLD_RST;
            cfg_reg.cooldown_ms <= COOLDOWN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/tdh_step.sv @@
// Next-state logic for one transaction: saturating time add, state rules, trigger.
// Depends on tdh_pkg.
module tdh_step
    import tdh_pkg::*;
(
    input  cfg_t              cfg,
    input  logic [StateW-1:0] state,
    input  logic [TimeW-1:0]  time_ms,
    input  logic [1:0]        func,
    input  logic [15:0]       confidence,
    input  logic [15:0]       delta_ms,
    output step_t             step
);

    logic [TimeW:0]      sum;
    logic [TimeW-1:0]    time_sat;
    logic [TimeW-1:0]    time_base;
    logic [StateW-1:0]   target;
    logic                fire;
    logic                above;

    always_comb
    begin
        sum      = {1'b0, time_ms} + {{(TimeW-15){1'b0}}, delta_ms};
        time_sat = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
        above    = confidence >= cfg.threshold;
        target   = state;
        fire     = 1'b0;
        time_base = time_ms;

        case (func)
            FN_UPDATE:
            begin
                time_base = time_sat;
                case (state)
                    ST_IDLE:
                        if (above)
                            target = ST_DETECTING;
                    ST_DETECTING:
                        if (!above)
                            target = ST_IDLE;
                        else if (time_sat >= {{(TimeW-CfgW){1'b0}}, cfg.hold_ms})
                        begin
                            target = ST_TRIGGERED;
                            fire   = 1'b1;
                        end
                    ST_TRIGGERED:
                        target = ST_COOLDOWN;
                    ST_COOLDOWN:
                        if (time_sat >= {{(TimeW-CfgW){1'b0}}, cfg.cooldown_ms})
                            target = ST_IDLE;
                    default:
                        target = state;
                endcase
            end
            FN_START:
                target = ST_TRAINING;
            FN_STOP:
                if (state == ST_TRAINING)
                    target = ST_IDLE;
            FN_RESET:
                target = ST_IDLE;
            default:
                target = state;
        endcase

        step.next_state = target;
        step.changed    = target != state;
        step.fired      = fire;
        step.next_time  = (target != state) ? '0 : time_base;
    end

endmodule

@@ rtl/tap_detect_hold_cooldown_fsm.sv @@
// Tap detector top level: input register, state update, result register.
// Input register, then result register; throughput one item per cycle while not stalled.
// Rate is set by the state and time registers, updated once per processed item.
// The result stage stalls when the result side holds tready low; the input stage then stalls once it holds an item.
// Reset (rst_n, async, active low) clears state to idle, time to zero, registers to defaults.
module tap_detect_hold_cooldown_fsm
    import tdh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [AddrW-1:0] cfg_addr,
    input  logic [CfgW-1:0]  cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,  // confidence[15:0], delta_ms[31:16]
    input  logic [1:0]       s_axis_tuser,  // func[1:0]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [39:0]      m_axis_tdata   // cur_state[2:0], prev_state[5:3],
                                            // state_changed[6], trigger_fired[7],
                                            // time_in_state_ms[39:8]
);

    cfg_t  cfg;
    step_t step;

    logic              in_valid_reg;
    logic [1:0]        func_reg;
    logic [15:0]       conf_reg;
    logic [15:0]       delta_reg;
    logic [StateW-1:0] state_reg;
    logic [TimeW-1:0]  time_reg;
    logic              out_valid_reg;
    logic [39:0]       out_data_reg;
    logic              out_free;
    logic              fire_item;

    tdh_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tdh_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .time_ms    (time_reg),
        .func       (func_reg),
        .confidence (conf_reg),
        .delta_ms   (delta_reg),
        .step       (step)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire_item     = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_IDLE;
            time_reg      <= '0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
            if (fire_item)
            begin
                state_reg <= step.next_state;
                time_reg  <= step.next_time;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            func_reg  <= s_axis_tuser;
            conf_reg  <= s_axis_tdata[15:0];
            delta_reg <= s_axis_tdata[31:16];
        end
        if (fire_item)
            out_data_reg <= {step.next_time, step.fired, step.changed,
                             state_reg, step.next_state};
    end

    a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE || state_reg == ST_TRAINING || state_reg == ST_DETECTING ||
        state_reg == ST_TRIGGERED || state_reg == ST_COOLDOWN)
        else $error("state register left the legal codes");

    a_change_clears_time: assert property (@(posedge clk) disable iff (!rst_n)
        fire_item && step.changed |=> time_reg == '0)
        else $error("time not cleared after a state change");

    a_fire_path: assert property (@(posedge clk) disable iff (!rst_n)
        fire_item && step.fired |-> state_reg == ST_DETECTING &&
            step.next_state == ST_TRIGGERED)
        else $error("trigger fired outside detecting to triggered");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        fire_item |=> out_valid_reg && out_data_reg[2:0] == state_reg)
        else $error("result register missed a processed item");

endmodule
